>>> sv/weak_pointer_intern_table_top_defines.svh
// ----------------------------------------------------------------------------
// Weak-pointer intern table: assertion macros
// Concurrent assertion wrappers shared by the RTL of the intern table.
// ----------------------------------------------------------------------------
`ifndef WEAK_POINTER_INTERN_TABLE_TOP_DEFINES_SVH
`define WEAK_POINTER_INTERN_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WPIT_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WPIT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/wpit_pkg.sv
// ----------------------------------------------------------------------------
// Weak-pointer intern table package
// Field widths, defaults, register map, control state and shared types.
// ----------------------------------------------------------------------------
package wpit_pkg;

  localparam int ObjW         = 32;
  localparam int WpW          = 12;
  localparam int DefWpEntries = 4096;
  localparam int DefHashSlots = 8191;

  // Fibonacci hashing multiplier
  localparam logic [ObjW-1:0] FibMult = 32'h9E37_79BB;

  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  // register index, taken from paddr[ApbAddrW-1:2]
  localparam logic [0:0] RegFalseRef = 1'b0;

  typedef enum logic {
    REQ_MAP  = 1'b0,
    REQ_READ = 1'b1
  } req_type_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_REV,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic            valid;
    logic [ObjW-1:0] obj;
    logic [WpW-1:0]  wp;
  } slot_word_t;

  typedef struct packed {
    logic [WpW-1:0]  wp_number;
    logic [ObjW-1:0] obj_out;
    logic            created;
    logic            false_input;
    logic            table_full;
    logic            bad_index;
  } rsp_t;

endpackage

>>> sv/wpit_if.sv
// ----------------------------------------------------------------------------
// Weak-pointer intern table channels
// Request and response valid/ready channels with their payload fields.
// ----------------------------------------------------------------------------
interface wpit_req_if;
  import wpit_pkg::*;

  logic            valid;
  logic            ready;
  logic            req_type;
  logic [ObjW-1:0] obj_ref;
  logic [WpW-1:0]  wp_query;

  modport source (output valid, req_type, obj_ref, wp_query, input ready);
  modport sink (input valid, req_type, obj_ref, wp_query, output ready);
endinterface

interface wpit_rsp_if;
  import wpit_pkg::*;

  logic            valid;
  logic            ready;
  logic [WpW-1:0]  wp_number;
  logic [ObjW-1:0] obj_out;
  logic            created;
  logic            false_input;
  logic            table_full;
  logic            bad_index;

  modport source (output valid, wp_number, obj_out, created, false_input, table_full,
                  bad_index, input ready);
  modport sink (input valid, wp_number, obj_out, created, false_input, table_full,
                bad_index, output ready);
endinterface

>>> sv/wpit_ram.sv
// ----------------------------------------------------------------------------
// Weak-pointer intern table RAM
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module wpit_ram #(
  parameter int Depth = 16,
  parameter int Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/wpit_hash.sv
// ----------------------------------------------------------------------------
// Weak-pointer intern table hash pipeline
// Fibonacci multiply, then modulo the slot count by reciprocal multiply and
// one correcting subtract. Four stages, slot index valid on done_o.
// ----------------------------------------------------------------------------
module wpit_hash #(
  parameter int HashSlots = wpit_pkg::DefHashSlots,
  parameter int SlotW     = $clog2(wpit_pkg::DefHashSlots)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [wpit_pkg::ObjW-1:0] obj_i,
  output logic                      done_o,
  output logic [SlotW-1:0]          slot_o
);
  import wpit_pkg::*;

  // floor(2^32 / HashSlots): quotient estimate is low by at most one
  localparam logic [31:0] Recip   = 32'((64'd1 << 32) / HashSlots);
  localparam logic [31:0] Slots32 = 32'(HashSlots);

  logic [3:0]       vld_q;
  logic [31:0]      key_lo;
  logic [63:0]      recip_prod;
  logic [31:0]      qn;
  logic [31:0]      rem_raw;
  logic [31:0]      rem_fix;
  logic [31:0]      key1_q, key2_q, key3_q, qest_q, qn_q;
  logic [SlotW-1:0] slot_q;

  assign key_lo     = obj_i * FibMult;
  assign recip_prod = {32'd0, key1_q} * {32'd0, Recip};
  assign qn         = qest_q * Slots32;
  assign rem_raw    = key3_q - qn_q;
  assign rem_fix    = (rem_raw >= Slots32) ? (rem_raw - Slots32) : rem_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    key1_q <= key_lo;
    key2_q <= key1_q;
    qest_q <= recip_prod[63:32];
    key3_q <= key2_q;
    qn_q   <= qn;
    slot_q <= rem_fix[SlotW-1:0];
  end

  assign done_o = vld_q[3];
  assign slot_o = slot_q;

endmodule

>>> sv/weak_pointer_intern_table_top.sv
// ----------------------------------------------------------------------------
// Weak-pointer intern table
// Interns object references as dense weak-pointer numbers in an open
// addressing hash table with linear probing, and reads references back.
// ----------------------------------------------------------------------------
//  port     | dir | protocol  | beat contents
//  ---------+-----+-----------+------------------------------------------------
//  req_i    | in  | valid/rdy | req_type, obj_ref, wp_query
//  rsp_o    | out | valid/rdy | wp_number, obj_out, created, false_input,
//           |     |           | table_full, bad_index
//  APB      | in  | psel/pen  | false_ref at byte address 0
//
//  After reset a clearing pass writes every slot invalid; no request beat is
//  taken meanwhile (APB writes still are). Map request: accept, hash wait,
//  probe of successive slots, response. Read request: accept, reverse-table
//  read, response. A map of the false reference or a read of an unassigned
//  number goes from accept to response. One request is in flight at a time;
//  the slot RAM read port sets the probe rate.
//  A finished beat waits in the output register; the next request is taken
//  meanwhile and only its final step holds on a stalled output.
// ----------------------------------------------------------------------------
`include "weak_pointer_intern_table_top_defines.svh"

module weak_pointer_intern_table_top #(
  parameter int WP_ENTRIES = wpit_pkg::DefWpEntries,
  parameter int HASH_SLOTS = wpit_pkg::DefHashSlots
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  wpit_req_if.sink                      req_i,
  wpit_rsp_if.source                    rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wpit_pkg::ApbAddrW-1:0] paddr,
  input  logic [wpit_pkg::ApbDataW-1:0] pwdata,
  output logic [wpit_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);
  import wpit_pkg::*;

  localparam int SlotW  = $clog2(HASH_SLOTS);
  localparam int ProbeW = $clog2(HASH_SLOTS + 1);
  localparam int CntW   = $clog2(WP_ENTRIES + 1);
  localparam int RevW   = $clog2(WP_ENTRIES);

  state_e             state_q, state_d;
  logic [ObjW-1:0]    false_ref_q, false_ref_d;
  logic [ObjW-1:0]    obj_q, obj_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [SlotW-1:0]   idx_q, idx_d;
  logic [SlotW-1:0]   idx_inc;
  logic [ProbeW-1:0]  probe_q, probe_d;
  logic [SlotW-1:0]   clr_q, clr_d;
  rsp_t               res_q, res_d;
  rsp_t               out_q;
  logic               out_valid_q, out_valid_d;

  logic               req_acc;
  logic               is_false;
  logic               rd_ok;
  logic               no_room;
  logic               hit;
  logic               last_probe;
  logic               last_clear;
  logic               out_free;
  logic               out_load;
  logic               cfg_wr;
  logic [0:0]         cfg_idx;

  logic               hash_start;
  logic               hash_done;
  logic [SlotW-1:0]   hash_slot;

  logic               slot_we;
  logic [SlotW-1:0]   slot_addr;
  slot_word_t         slot_wdata;
  slot_word_t         slot_rd;
  logic               rev_we;
  logic [RevW-1:0]    rev_addr;
  logic [ObjW-1:0]    rev_rd;
  logic [3:0]         flag_vec;

  wpit_hash #(
    .HashSlots (HASH_SLOTS),
    .SlotW     (SlotW)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .obj_i   (req_i.obj_ref),
    .done_o  (hash_done),
    .slot_o  (hash_slot)
  );

  wpit_ram #(
    .Depth (HASH_SLOTS),
    .Width ($bits(slot_word_t))
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .addr_i  (slot_addr),
    .wdata_i (slot_wdata),
    .rdata_o (slot_rd)
  );

  wpit_ram #(
    .Depth (WP_ENTRIES),
    .Width (ObjW)
  ) u_rev_ram (
    .clk_i   (clk_i),
    .we_i    (rev_we),
    .addr_i  (rev_addr),
    .wdata_i (obj_q),
    .rdata_o (rev_rd)
  );

  // ---------------------------------------------------------------- APB ----
  assign pready  = 1'b1;
  assign cfg_idx = paddr[ApbAddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = (cfg_idx == RegFalseRef) ? false_ref_q : '0;

  always_comb begin
    false_ref_d = false_ref_q;
    if (cfg_wr && (cfg_idx == RegFalseRef)) begin
      false_ref_d = pwdata;
    end
  end

  // ----------------------------------------------------------- decode -------
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign is_false    = (req_i.obj_ref == false_ref_q);
  assign rd_ok       = (32'(req_i.wp_query) < 32'(cnt_q))
                    && (32'(req_i.wp_query) < 32'(WP_ENTRIES));
  // keep the table under half full and within the number space
  assign no_room     = (32'(cnt_q) >= 32'(WP_ENTRIES))
                    || (((32'(cnt_q) + 32'd1) << 1) >= 32'(HASH_SLOTS));
  assign hit         = slot_rd.valid && (slot_rd.obj == obj_q);
  assign last_probe  = (probe_q == ProbeW'(HASH_SLOTS - 1));
  assign last_clear  = (clr_q == SlotW'(HASH_SLOTS - 1));
  assign idx_inc     = (idx_q == SlotW'(HASH_SLOTS - 1)) ? '0 : idx_q + 1'b1;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign out_load    = (state_q == ST_RESP) && out_free;

  // ------------------------------------------------------- next state -------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (last_clear) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_acc) begin
          if (req_i.req_type == REQ_READ) begin
            state_d = rd_ok ? ST_REV : ST_RESP;
          end else begin
            state_d = is_false ? ST_RESP : ST_HASH;
          end
        end
      end
      ST_HASH: begin
        if (hash_done) state_d = ST_PROBE;
      end
      ST_PROBE: begin
        if (!slot_rd.valid || hit || last_probe) state_d = ST_RESP;
      end
      ST_REV: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------- datapath ------
  always_comb begin
    res_d      = res_q;
    obj_d      = obj_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    probe_d    = probe_q;
    clr_d      = clr_q;
    hash_start = 1'b0;
    slot_we    = 1'b0;
    slot_wdata = '0;
    rev_we     = 1'b0;
    rev_addr   = RevW'(req_i.wp_query);
    case (state_q)
      ST_CLEAR: begin
        slot_we = 1'b1;
        clr_d   = clr_q + 1'b1;
      end
      ST_IDLE: begin
        if (req_acc) begin
          obj_d = req_i.obj_ref;
          res_d = '0;
          if (req_i.req_type == REQ_READ) begin
            res_d.bad_index = !rd_ok;
          end else if (is_false) begin
            res_d.false_input = 1'b1;
          end else begin
            hash_start = 1'b1;
          end
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          idx_d   = hash_slot;
          probe_d = '0;
        end
      end
      ST_PROBE: begin
        if (!slot_rd.valid) begin
          if (no_room) begin
            res_d.table_full = 1'b1;
          end else begin
            slot_we          = 1'b1;
            slot_wdata.valid = 1'b1;
            slot_wdata.obj   = obj_q;
            slot_wdata.wp    = WpW'(cnt_q);
            rev_we           = 1'b1;
            rev_addr         = cnt_q[RevW-1:0];
            res_d.created    = 1'b1;
            res_d.wp_number  = WpW'(cnt_q);
            cnt_d            = cnt_q + 1'b1;
          end
        end else if (hit) begin
          res_d.wp_number = slot_rd.wp;
        end else if (last_probe) begin
          res_d.table_full = 1'b1;
        end else begin
          // advance and read the next slot in the same cycle
          idx_d   = idx_inc;
          probe_d = probe_q + 1'b1;
        end
      end
      ST_REV: begin
        res_d.obj_out = rev_rd;
      end
      ST_RESP: begin
        res_d = res_q;
      end
      default: begin
        res_d = res_q;
      end
    endcase
  end

  assign slot_addr = (state_q == ST_CLEAR) ? clr_q : idx_d;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // ---------------------------------------------------------- registers -----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      false_ref_q <= '0;
      cnt_q       <= '0;
      clr_q       <= '0;
      idx_q       <= '0;
      probe_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      false_ref_q <= false_ref_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
      idx_q       <= idx_d;
      probe_q     <= probe_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obj_q <= obj_d;
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  // ------------------------------------------------------------ outputs -----
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.wp_number   = out_q.wp_number;
  assign rsp_o.obj_out     = out_q.obj_out;
  assign rsp_o.created     = out_q.created;
  assign rsp_o.false_input = out_q.false_input;
  assign rsp_o.table_full  = out_q.table_full;
  assign rsp_o.bad_index   = out_q.bad_index;

  // --------------------------------------------------------- assertions -----
  assign flag_vec = {out_q.created, out_q.false_input, out_q.table_full, out_q.bad_index};

  `WPIT_ASSERT_NEXT(a_cnt_step, clk_i, rst_ni, (state_q == ST_PROBE) && rev_we, cnt_q == $past(cnt_q) + 1'b1, "entry count did not advance on create")
  `WPIT_ASSERT_IMPL(a_one_flag, clk_i, rst_ni, out_valid_q, $countones(flag_vec) <= 1, "more than one status flag in a response")
  `WPIT_ASSERT_IMPL(a_hash_wait, clk_i, rst_ni, hash_done, state_q == ST_HASH, "hash result arrived outside hash wait")

endmodule

>>> verif/weak_pointer_intern_table_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weak-pointer intern table testbench
// Sends map and read requests over the valid/ready channels with random gaps
// and stalls on both sides. The false reference is written over APB between
// phases. Each response beat is checked against a scoreboard that keeps its
// own copy of the slot table, the reverse table and the entry count. The run
// ends with requests at the first, the last and the next unassigned number.
// ----------------------------------------------------------------------------
module weak_pointer_intern_table_top_tb;
  import wpit_pkg::*;

  localparam int         WpEntries     = DefWpEntries;
  localparam int         HashSlots     = DefHashSlots;
  localparam int         HalfPeriodNs  = 2;
  localparam int         ResetCycles   = 7;
  localparam int         RandomItems   = 520;
  localparam int         LongHold      = 250;
  localparam int         DrainCycles   = 40;
  // covers the clearing pass after reset, the long hold and the longest probe chain
  localparam int         StallLimit    = 30000;
  localparam int         MaxReports    = 40;
  localparam logic [0:0] RegOutOfRange = 1'b1;

  class intern_scoreboard;
    bit              slot_used  [HashSlots];
    logic [ObjW-1:0] slot_ref   [HashSlots];
    logic [WpW-1:0]  slot_num   [HashSlots];
    logic [ObjW-1:0] ref_of_num [WpEntries];
    int unsigned     num_assigned;
    logic [ObjW-1:0] false_value = '0;
    rsp_t            expected_q [$];
    int unsigned     mismatches;

    function int unsigned home_of(logic [ObjW-1:0] obj);
      logic [ObjW-1:0] key;
      key = obj * FibMult;
      return key % HashSlots;
    endfunction

    function void note_request(req_type_e kind, logic [ObjW-1:0] obj,
                               logic [WpW-1:0] query);
      rsp_t        want;
      int unsigned idx;
      int unsigned probes;
      want = '0;
      if (kind == REQ_READ) begin
        if (query < num_assigned) want.obj_out = ref_of_num[query];
        else want.bad_index = 1'b1;
      end else if (obj == false_value) begin
        want.false_input = 1'b1;
      end else begin
        idx    = home_of(obj);
        probes = 0;
        while (probes < HashSlots && slot_used[idx] && slot_ref[idx] != obj) begin
          idx = (idx == HashSlots - 1) ? 0 : idx + 1;
          probes++;
        end
        if (probes < HashSlots && slot_used[idx]) begin
          want.wp_number = slot_num[idx];
        end else if (probes == HashSlots || num_assigned >= WpEntries ||
                     2 * (num_assigned + 1) >= HashSlots) begin
          want.table_full = 1'b1;
        end else begin
          slot_used[idx]           = 1'b1;
          slot_ref[idx]            = obj;
          slot_num[idx]            = WpW'(num_assigned);
          ref_of_num[num_assigned] = obj;
          want.wp_number           = WpW'(num_assigned);
          want.created             = 1'b1;
          num_assigned++;
        end
      end
      expected_q.push_back(want);
    endfunction

    function void compare_field(string field, logic [ObjW-1:0] want, logic [ObjW-1:0] seen);
      if (seen !== want) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, seen);
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $error("response beat with nothing expected: wp_number 0x%0h obj_out 0x%0h",
                 got.wp_number, got.obj_out);
        return;
      end
      want = expected_q.pop_front();
      compare_field("wp_number", want.wp_number, got.wp_number);
      compare_field("obj_out", want.obj_out, got.obj_out);
      compare_field("created", want.created, got.created);
      compare_field("false_input", want.false_input, got.false_input);
      compare_field("table_full", want.table_full, got.table_full);
      compare_field("bad_index", want.bad_index, got.bad_index);
    endfunction
  endclass

  intern_scoreboard sb = new;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  int                  idle_pct;
  bit                  long_hold_req;
  int unsigned         quiet_cycles = 0;

  wpit_req_if req_if ();
  wpit_rsp_if rsp_if ();

  weak_pointer_intern_table_top #(
    .WP_ENTRIES(WpEntries),
    .HASH_SLOTS(HashSlots)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #(HalfPeriodNs) clk_i = ~clk_i;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return $urandom_range(3, 1);
    if (roll < 95) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic send_req(input req_type_e kind, input logic [ObjW-1:0] obj,
                          input logic [WpW-1:0] query);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.obj_ref  <= obj;
    req_if.wp_query <= query;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(kind, obj, query);
  endtask

  task automatic wait_all_results();
    req_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ApbAddrW-3:0] reg_idx, input logic [ApbDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (reg_idx == RegFalseRef) sb.false_value = value;
    // read false_ref back; a write out of range must leave it alone
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {RegFalseRef, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.compare_field("false_ref", sb.false_value, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [ObjW-1:0] wrap_refs [3];
    logic [ObjW-1:0] cand;
    logic [ObjW-1:0] rand_obj;
    logic [WpW-1:0]  rand_query;
    int              found;
    int              pick;

    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    req_if.valid    <= 1'b0;
    req_if.req_type <= REQ_MAP;
    req_if.obj_ref  <= '0;
    req_if.wp_query <= '0;
    idle_pct      = 0;
    long_hold_req = 1'b0;

    // collect three references homed on the last slot so their probes wrap
    cand  = $urandom;
    found = 0;
    while (found < 3) begin
      if (sb.home_of(cand) == HashSlots - 1 && cand != '0 && cand != '1) begin
        wrap_refs[found] = cand;
        found++;
      end
      cand++;
    end

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_reg(RegFalseRef, '0);

    // directed: empty table, extremes, wraparound probing
    send_req(REQ_READ, $urandom, '0);
    send_req(REQ_READ, $urandom, '1);
    send_req(REQ_MAP, '0, WpW'($urandom));
    send_req(REQ_MAP, '1, WpW'($urandom));
    send_req(REQ_MAP, '1, WpW'($urandom));
    send_req(REQ_READ, $urandom, 12'd0);
    send_req(REQ_READ, $urandom, 12'd1);
    for (int k = 0; k < 3; k++) send_req(REQ_MAP, wrap_refs[k], WpW'($urandom));
    send_req(REQ_MAP, wrap_refs[2], WpW'($urandom));
    send_req(REQ_MAP, wrap_refs[1], WpW'($urandom));
    send_req(REQ_READ, $urandom, 12'd3);
    send_req(REQ_MAP, 32'd1, WpW'($urandom));
    send_req(REQ_MAP, 32'h8000_0000, WpW'($urandom));
    wait_all_results();

    // move false onto an interned reference; zero becomes an ordinary one
    write_reg(RegFalseRef, '1);
    write_reg(RegOutOfRange, 32'h5A5A_A5A5);
    send_req(REQ_MAP, '1, WpW'($urandom));
    send_req(REQ_MAP, '0, WpW'($urandom));
    send_req(REQ_READ, $urandom, 12'd0);
    send_req(REQ_MAP, '0, WpW'($urandom));
    wait_all_results();
    write_reg(RegFalseRef, $urandom);

    for (int i = 0; i < RandomItems; i++) begin
      if (i == 60) idle_pct = 30;
      if (i == 80) long_hold_req = 1'b1;
      if (i == 150) wait_all_results();
      if (i == RandomItems / 2) begin
        wait_all_results();
        write_reg(RegFalseRef, '0);
        write_reg(RegOutOfRange, $urandom);
      end
      if (i == 420) idle_pct = 60;
      rand_obj   = $urandom;
      rand_query = WpW'($urandom);
      pick       = $urandom_range(99);
      if (pick < 35) begin
        send_req(REQ_MAP, rand_obj, rand_query);
      end else if (pick < 55 && sb.num_assigned > 0) begin
        send_req(REQ_MAP, sb.ref_of_num[$urandom_range(sb.num_assigned - 1)], rand_query);
      end else if (pick < 60) begin
        send_req(REQ_MAP, sb.false_value, rand_query);
      end else if (pick < 80 && sb.num_assigned > 0) begin
        send_req(REQ_READ, rand_obj, WpW'($urandom_range(sb.num_assigned - 1)));
      end else if (pick < 88) begin
        send_req(REQ_READ, rand_obj, WpW'(sb.num_assigned + $urandom_range(2)));
      end else begin
        send_req(REQ_READ, rand_obj, rand_query);
      end
    end

    // closing requests around the assigned range
    wait_all_results();
    write_reg(RegFalseRef, $urandom);
    idle_pct = 15;
    for (int k = 0; k < 6; k++) send_req(REQ_MAP, $urandom, WpW'($urandom));
    send_req(REQ_MAP, sb.ref_of_num[0], WpW'($urandom));
    send_req(REQ_MAP, sb.ref_of_num[sb.num_assigned - 1], WpW'($urandom));
    send_req(REQ_READ, $urandom, WpW'(sb.num_assigned - 1));
    send_req(REQ_READ, $urandom, WpW'(sb.num_assigned));
    send_req(REQ_MAP, sb.false_value, WpW'($urandom));
    wait_all_results();

    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("weak_pointer_intern_table_top_tb passed");
    end else begin
      $display("weak_pointer_intern_table_top_tb failed");
    end
    $finish;
  end

  initial begin : response_sink
    int stall_left;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        sb.check_response('{wp_number:   rsp_if.wp_number,
                            obj_out:     rsp_if.obj_out,
                            created:     rsp_if.created,
                            false_input: rsp_if.false_input,
                            table_full:  rsp_if.table_full,
                            bad_index:   rsp_if.bad_index});
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LongHold;
      end else if (stall_left == 0 && $urandom_range(99) < idle_pct / 3) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // count cycles without a beat on either channel
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("weak_pointer_intern_table_top_tb failed");
      $finish;
    end
  end

endmodule

>>> weak_pointer_intern_table_top.f
+incdir+sv
sv/wpit_pkg.sv
sv/wpit_if.sv
sv/wpit_ram.sv
sv/wpit_hash.sv
sv/weak_pointer_intern_table_top.sv
verif/weak_pointer_intern_table_top_tb.sv
